>>> hw/rtl/avm_pkg.sv
// Shared types, constants and lookup functions for the averaging voltmeter.
// No dependencies; every other RTL file of the block refers to this package.
`default_nettype none

package avm_pkg;

  // Field widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned SegW    = 7;
  localparam int unsigned VoltsW  = 6;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned BcdW    = 2 * DigitW;
  localparam int unsigned ScaledW = 16;

  // Samples summed per displayed average
  localparam int unsigned DefSamplesPerAverage = 8;

  // Scale to tenths of a volt: (avg * ScaleMul + ScaleRound) / FullScale.
  // FullScale is one below a power of two, so the quotient is a shift plus
  // a single correction.
  localparam int unsigned ScaleMul   = 33;
  localparam int unsigned ScaleRound = 511;
  localparam int unsigned FullScale  = 1023;

  // One queued item after classification
  typedef struct packed {
    logic               is_tick;
    logic [SampleW-1:0] sample;
  } item_t;

  // Split a small binary value (at most 63) into tens and units digits
  function automatic logic [BcdW-1:0] to_bcd(input logic [VoltsW-1:0] v);
    logic [DigitW-1:0] tens;
    logic [VoltsW-1:0] rest;
    if (v >= VoltsW'(60))      tens = DigitW'(6);
    else if (v >= VoltsW'(50)) tens = DigitW'(5);
    else if (v >= VoltsW'(40)) tens = DigitW'(4);
    else if (v >= VoltsW'(30)) tens = DigitW'(3);
    else if (v >= VoltsW'(20)) tens = DigitW'(2);
    else if (v >= VoltsW'(10)) tens = DigitW'(1);
    else                       tens = DigitW'(0);
    rest = v - (VoltsW'(tens) * VoltsW'(10));
    return {tens, rest[DigitW-1:0]};
  endfunction

  // Hex seven-segment pattern, bit 0 = segment a .. bit 6 = segment g
  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] seg;
    case (d)
      4'h0:    seg = 7'h3F;
      4'h1:    seg = 7'h06;
      4'h2:    seg = 7'h5B;
      4'h3:    seg = 7'h4F;
      4'h4:    seg = 7'h66;
      4'h5:    seg = 7'h6D;
      4'h6:    seg = 7'h7D;
      4'h7:    seg = 7'h07;
      4'h8:    seg = 7'h7F;
      4'h9:    seg = 7'h6F;
      4'hA:    seg = 7'h77;
      4'hB:    seg = 7'h7C;
      4'hC:    seg = 7'h39;
      4'hD:    seg = 7'h5E;
      4'hE:    seg = 7'h79;
      4'hF:    seg = 7'h71;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/avm_stream_if.sv
// Valid/ready channel interfaces for the voltmeter input and display output.
// Depends on avm_pkg for the field widths.
`default_nettype none

interface avm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [avm_pkg::SampleW-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

interface avm_out_if;
  logic                     valid;
  logic                     ready;
  logic [avm_pkg::SegW-1:0] segments;
  logic                     high_digit_on;
  logic                     low_digit_on;

  modport source (output valid, segments, high_digit_on, low_digit_on, input ready);
  modport sink   (input valid, segments, high_digit_on, low_digit_on, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/avm_front.sv
// Front end: accepts input transfers, tags samples and ticks, and queues them.
// Depends on avm_pkg and avm_in_if.
`default_nettype none

module avm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  avm_in_if.sink               in_i,
  output      logic            q_valid_o,
  output      avm_pkg::item_t  q_item_o,
  input  wire logic            q_ready_i
);

  localparam int unsigned Depth = 2;

  avm_pkg::item_t   entry_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;
  avm_pkg::item_t   in_item;

  // Classify the incoming transfer
  assign in_item.is_tick = in_i.command;
  assign in_item.sample  = in_i.sample;

  assign in_i.ready = (cnt_q != 2'(Depth));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry on a push
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/avm_back.sv
// Back end: accumulates samples, averages and scales each group, keeps the
// BCD value and drives the multiplexed digit output. Depends on avm_pkg.
`default_nettype none

module avm_back #(
  parameter int unsigned SamplesPerAverage = avm_pkg::DefSamplesPerAverage
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire avm_pkg::item_t  q_item_i,
  output      logic            q_ready_o,
  avm_out_if.source            out_o
);

  localparam int unsigned SumW    = $clog2(SamplesPerAverage * avm_pkg::FullScale + 1);
  localparam int unsigned CntW    = (SamplesPerAverage > 1) ? $clog2(SamplesPerAverage) : 1;
  // Reciprocal for the divide by the group size: exact for any sum below 2**SumW
  localparam int unsigned ShiftK   = SumW + $clog2(SamplesPerAverage) + 1;
  localparam int unsigned RecipW   = ShiftK + 1;
  localparam int unsigned RecipInt = ((1 << ShiftK) + SamplesPerAverage - 1) / SamplesPerAverage;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam int unsigned SW       = avm_pkg::SampleW;
  localparam int unsigned VW       = avm_pkg::VoltsW;
  localparam int unsigned TW       = avm_pkg::ScaledW;
  localparam int unsigned LowW     = TW - VW;

  logic                       adv;

  // Accumulator
  logic [SumW-1:0]            sum_q, sum_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [SumW-1:0]            sum_total;
  logic                       last;
  logic                       take_sample;

  // Stage 1: group total
  logic                       s1_valid_q, s1_tick_q, s1_done_q;
  logic [SumW-1:0]            s1_sum_q;
  // Stage 2: average
  logic                       s2_valid_q, s2_tick_q, s2_done_q;
  logic [SW-1:0]              s2_avg_q;
  logic [ProdW-1:0]           prod;
  // Stage 3: scaled value in tenths of a volt
  logic                       s3_valid_q, s3_tick_q, s3_done_q;
  logic [VW-1:0]              s3_volts_q;
  logic [TW-1:0]              scaled;
  logic [VW-1:0]              quot0;
  logic [LowW:0]              rem;
  logic [VW-1:0]              volts;

  // Display state and output register
  logic [avm_pkg::BcdW-1:0]   bcd_q;
  logic                       phase_q;
  logic                       out_valid_q;
  logic [avm_pkg::SegW-1:0]   seg_q;
  logic                       high_on_q;
  logic [avm_pkg::DigitW-1:0] digit;

  // Whole pipeline moves when the output register can take a result
  assign adv       = !out_valid_q || out_o.ready;
  assign q_ready_o = adv;

  // Accumulate samples of the current group
  assign take_sample = adv && q_valid_i && !q_item_i.is_tick;
  assign sum_total   = sum_q + SumW'(q_item_i.sample);
  assign last        = (cnt_q == CntW'(SamplesPerAverage - 1));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (take_sample) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_total;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Divide by the group size through the reciprocal
  assign prod = ProdW'(s1_sum_q) * ProdW'(RecipW'(RecipInt));

  // Scale: t = avg*33 + 511, then t / 1023 as t >> 10 with one correction
  assign scaled = TW'(s2_avg_q) * TW'(avm_pkg::ScaleMul) + TW'(avm_pkg::ScaleRound);
  assign quot0  = scaled[TW-1:LowW];
  assign rem    = {1'b0, scaled[LowW-1:0]} + (LowW+1)'(quot0);
  assign volts  = quot0 + VW'(rem >= (LowW+1)'(avm_pkg::FullScale));

  // Pick the digit to show on this tick
  assign digit = phase_q ? bcd_q[avm_pkg::DigitW-1:0]
                         : bcd_q[avm_pkg::BcdW-1:avm_pkg::DigitW];

  // Pipeline control, display state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_tick_q   <= 1'b0;
      s1_done_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_tick_q   <= 1'b0;
      s2_done_q   <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_tick_q   <= 1'b0;
      s3_done_q   <= 1'b0;
      bcd_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      // Drop samples that do not close a group
      s1_valid_q  <= q_valid_i && (q_item_i.is_tick || last);
      s1_tick_q   <= q_item_i.is_tick;
      s1_done_q   <= q_valid_i && !q_item_i.is_tick && last;
      s2_valid_q  <= s1_valid_q;
      s2_tick_q   <= s1_tick_q;
      s2_done_q   <= s1_valid_q && s1_done_q;
      s3_valid_q  <= s2_valid_q;
      s3_tick_q   <= s2_tick_q;
      s3_done_q   <= s2_valid_q && s2_done_q;
      if (s3_valid_q && s3_done_q) begin
        bcd_q <= avm_pkg::to_bcd(s3_volts_q);
      end
      if (s3_valid_q && s3_tick_q) begin
        phase_q <= ~phase_q;
      end
      out_valid_q <= s3_valid_q && s3_tick_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q   <= sum_total;
      s2_avg_q   <= prod[ShiftK +: SW];
      s3_volts_q <= volts;
      if (s3_valid_q && s3_tick_q) begin
        seg_q     <= avm_pkg::seg_of(digit);
        high_on_q <= !phase_q;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.segments      = seg_q;
  assign out_o.high_digit_on = high_on_q;
  assign out_o.low_digit_on  = !high_on_q;

endmodule

`default_nettype wire

>>> hw/rtl/adc_average_voltmeter_display_core.sv
// A refresh tick passes the front queue and the back-end stage registers to the output register.
// Throughput: one item per cycle; the front queue and the back pipeline move
// together whenever the output register is empty or being read.
// Reset (rst_ni low, asynchronous): sum, count, displayed value and digit
// phase clear, so the display shows "00" with the high digit first.
// Top level of the averaging voltmeter; depends on avm_pkg, avm_stream_if,
// avm_front and avm_back.
`default_nettype none

module adc_average_voltmeter_display_core #(
  parameter int unsigned SamplesPerAverage = avm_pkg::DefSamplesPerAverage
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  avm_in_if.sink    in_i,
  avm_out_if.source out_o
);

  logic           q_valid;
  logic           q_ready;
  avm_pkg::item_t q_item;

  // Accept and queue items
  avm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  // Average, scale and display
  avm_back #(
    .SamplesPerAverage (SamplesPerAverage)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

  // An accepted transfer is in the queue in the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> q_valid)
    else $error("accepted item missing from queue");

  // A held result stalls the back end
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !q_ready)
    else $error("back end advanced while result held");

  // Exactly one digit is enabled with each result
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.high_digit_on != out_o.low_digit_on))
    else $error("digit enables not exclusive");

endmodule

`default_nettype wire

>>> test/tb_adc_average_voltmeter_display_core.sv
// Self-checking testbench for adc_average_voltmeter_display_core: directed table, then random
// sample groups and refresh ticks under bursty input and stalling output, checked per field.
// Depends on avm_pkg, avm_stream_if and the core RTL.
`default_nettype none

module tb_adc_average_voltmeter_display_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GROUP       = avm_pkg::DefSamplesPerAverage;
  localparam int unsigned RANDOM_ITEMS = 1580;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned N_DIRECTED  = 22;

  typedef enum logic {CMD_SAMPLE = 1'b0, CMD_TICK = 1'b1} cmd_e;
  typedef enum logic [1:0] {RDY_FREE, RDY_TOGGLE, RDY_SPARSE, RDY_BLOCKS} rdy_mode_e;

  typedef struct packed {
    logic [avm_pkg::SegW-1:0] segments;
    logic                     high_on;
    logic                     low_on;
  } disp_t;

  typedef struct packed {
    cmd_e                        cmd;
    logic [avm_pkg::SampleW-1:0] smp;
    logic                        chk;
    disp_t                       want;
  } stim_row_t;

  // Hex glyphs, segment a in bit 0
  localparam logic [6:0] GLYPH [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  localparam disp_t NO_CHECK  = '0;
  localparam disp_t ZERO_HI   = '{7'h3F, 1'b1, 1'b0};
  localparam disp_t ZERO_LO   = '{7'h3F, 1'b0, 1'b1};
  localparam disp_t THREE_HI  = '{7'h4F, 1'b1, 1'b0};
  localparam disp_t THREE_LO  = '{7'h4F, 1'b0, 1'b1};

  // Power-up display, full-scale group (3.3 V), zero group, ignored sample on ticks
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_TICK,   10'd0,    1'b1, ZERO_HI},
    '{CMD_TICK,   10'd1023, 1'b1, ZERO_LO},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd1023, 1'b0, NO_CHECK},
    '{CMD_TICK,   10'd0,    1'b1, THREE_HI},
    '{CMD_TICK,   10'd1023, 1'b1, THREE_LO},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_SAMPLE, 10'd0,    1'b0, NO_CHECK},
    '{CMD_TICK,   10'd1023, 1'b1, ZERO_HI},
    '{CMD_TICK,   10'd0,    1'b1, ZERO_LO}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  avm_in_if  in_if ();
  avm_out_if out_if ();

  adc_average_voltmeter_display_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wire in_fire  = in_if.valid && in_if.ready;
  wire out_fire = out_if.valid && out_if.ready;

  // Meter state mirror
  logic [12:0] acc_sum;
  int unsigned acc_cnt;
  logic [7:0]  shown_digits;
  logic        low_next;
  logic [33:0] volts_seen;

  // Sideband driven with each item: a typed-in expectation for table rows
  logic  row_chk;
  disp_t row_want;

  disp_t       display_q [$];
  int unsigned errors;
  int unsigned samples_taken, ticks_taken, groups_done, results_checked;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // Advance the meter by one accepted item; returns 1 when a display transfer follows
  function automatic logic meter_step(input cmd_e cmd, input logic [9:0] smp,
                                      output disp_t shown);
    int unsigned mean;
    int unsigned tenths;
    shown = '0;
    if (cmd == CMD_SAMPLE) begin
      samples_taken++;
      acc_sum = acc_sum + 13'(smp);
      acc_cnt++;
      if (acc_cnt == GROUP) begin
        mean   = int'(acc_sum) / GROUP;
        tenths = (mean * 33 + 511) / 1023;
        shown_digits = {4'(tenths / 10), 4'(tenths % 10)};
        volts_seen[tenths] = 1'b1;
        groups_done++;
        acc_sum = '0;
        acc_cnt = 0;
      end
      return 1'b0;
    end
    ticks_taken++;
    if (!low_next) shown = '{GLYPH[shown_digits[7:4]], 1'b1, 1'b0};
    else           shown = '{GLYPH[shown_digits[3:0]], 1'b0, 1'b1};
    low_next = ~low_next;
    return 1'b1;
  endfunction

  // Drive one item and hold it until the transfer
  task automatic put_item(input cmd_e cmd, input logic [9:0] smp, input logic chk,
                          input disp_t want);
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.sample  <= smp;
    row_chk       <= chk;
    row_want      <= want;
    @(posedge clk_i);
    while (!in_fire) @(posedge clk_i);
  endtask

  // Bursts of random length with random gaps, sometimes back to back
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold the sender until every expected display transfer has arrived
  task automatic drain_display();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (display_q.size() != 0) @(posedge clk_i);
  endtask

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern: switch between free, toggling, sparse and blocked modes
  rdy_mode_e   rdy_mode = RDY_FREE;
  int unsigned rdy_mode_left = 0;
  int unsigned rdy_phase = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rdy_mode_left == 0) begin
        rdy_mode      <= rdy_mode_e'($urandom_range(0, 3));
        rdy_mode_left <= $urandom_range(20, 80);
      end else begin
        rdy_mode_left <= rdy_mode_left - 1;
      end
      rdy_phase <= rdy_phase + 1;
      case (rdy_mode)
        RDY_FREE:   out_if.ready <= 1'b1;
        RDY_TOGGLE: out_if.ready <= ~out_if.ready;
        RDY_SPARSE: out_if.ready <= ($urandom_range(0, 3) != 0);
        default:    out_if.ready <= ((rdy_phase % 16) >= 10);
      endcase
    end
  end

  // Check display transfers against the oldest expectation; predict on input transfers
  always @(posedge clk_i) begin
    disp_t got;
    disp_t want;
    disp_t predicted;
    if (out_fire) begin
      got = '{out_if.segments, out_if.high_digit_on, out_if.low_digit_on};
      if (display_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected display transfer seg=%h hi=%b lo=%b",
                 $time, got.segments, got.high_on, got.low_on);
      end else begin
        want = display_q.pop_front();
        results_checked++;
        if (got.segments !== want.segments) begin
          errors++;
          $display("%0t: segments expected %h actual %h", $time, want.segments, got.segments);
        end
        if (got.high_on !== want.high_on) begin
          errors++;
          $display("%0t: high_digit_on expected %b actual %b", $time, want.high_on,
                   got.high_on);
        end
        if (got.low_on !== want.low_on) begin
          errors++;
          $display("%0t: low_digit_on expected %b actual %b", $time, want.low_on, got.low_on);
        end
      end
    end
    if (in_fire) begin
      if (meter_step(cmd_e'(in_if.command), in_if.sample, predicted))
        display_q.push_back(row_chk ? row_want : predicted);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else                     idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_adc_average_voltmeter_display_core: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned level;
    int unsigned spread;
    int unsigned in_group;
    int          v;
    in_if.valid   = 1'b0;
    in_if.command = CMD_SAMPLE;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    row_chk       = 1'b0;
    row_want      = NO_CHECK;
    acc_sum       = '0;
    acc_cnt       = 0;
    shown_digits  = '0;
    low_next      = 1'b0;
    volts_seen    = '0;
    errors        = 0;
    samples_taken = 0;
    ticks_taken   = 0;
    groups_done   = 0;
    results_checked = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    level         = 0;
    spread        = 0;
    in_group      = 0;

    // Hold reset, then release
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      put_item(DIRECTED[i].cmd, DIRECTED[i].smp, DIRECTED[i].chk, DIRECTED[i].want);
      pace_sender();
    end
    drain_display();

    // Random groups: one level per group, tight, loose or fully random spread
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_display();
      if ($urandom_range(0, 99) < 35) begin
        put_item(CMD_TICK, 10'($urandom_range(0, 1023)), 1'b0, NO_CHECK);
      end else begin
        if (in_group == 0) begin
          level  = $urandom_range(0, 1023);
          spread = $urandom_range(0, 2);
        end
        case (spread)
          0:       v = level;
          1:       v = int'(level) + $urandom_range(0, 32) - 16;
          default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0)    v = 0;
        if (v > 1023) v = 1023;
        put_item(CMD_SAMPLE, 10'(v), 1'b0, NO_CHECK);
        in_group = (in_group + 1) % GROUP;
      end
      pace_sender();
    end

    // Drain and let the pipeline settle
    drain_display();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d samples in %0d averages and %0d refresh ticks, %0d displays checked.",
             samples_taken, groups_done, ticks_taken, results_checked);
    $display("Averages reached %0d of the 34 voltage codes from 0.0 V to 3.3 V.",
             $countones(volts_seen));
    if (errors == 0) begin
      $display("tb_adc_average_voltmeter_display_core: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_adc_average_voltmeter_display_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
